### hw/rtl/bchs_pkg.sv
// shared types and constants of the button click and hold scanner
package bchs_pkg;

    localparam int NUM_BUTTONS_DEF = 4;
    localparam int TIME_BITS_DEF   = 32;

    localparam int CFG_BITS  = 16;
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    localparam logic [CFG_BITS-1:0] SCAN_INTERVAL_RST = 16'd10;
    localparam logic [CFG_BITS-1:0] HOLD_LIMIT_RST    = 16'd500;

    // register index, taken from paddr[2]
    localparam logic REG_SCAN_INTERVAL = 1'b0;
    localparam logic REG_HOLD_LIMIT    = 1'b1;

    typedef logic [1:0] t_event;

    localparam t_event EV_IDLE  = 2'd0;
    localparam t_event EV_CLICK = 2'd1;
    localparam t_event EV_HELD  = 2'd2;

endpackage

### hw/rtl/button_click_hold_scanner.sv
// button click and long-press scanner, top level
//
// input channel (i_valid / o_stall): one transaction is one time tick with the raw
// active-low button levels and a mask of clicks to read and clear.
// output channel (o_valid / i_stall): one transaction per tick with the pending click
// mask, the held mask and a flag telling whether the tick ran a sampling pass.
// a tick is captured in the input register, then all buttons are evaluated in
// parallel and the result register and button state load together.
// throughput is one tick per cycle unless the receiver stalls, set by the single evaluation stage.
// when the receiver stalls, the result register holds; a new tick is still taken
// while the input register is free, and o_stall rises only when both stages are full.
// reset (synchronous, active low) clears the tick counter, last scan time, press
// state and events, and loads scan interval = 10 and hold limit = 500.
// configuration goes through the APB-style port: scan interval at 0x0, hold limit at
// 0x4; the user writes them only while no tick is in flight, which the block does not enforce; pready is always high.
module button_click_hold_scanner #(
    parameter int NUM_BUTTONS = bchs_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = bchs_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tick input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [NUM_BUTTONS-1:0]         i_pin_levels,
    input  logic [NUM_BUTTONS-1:0]         i_read_clicks,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [NUM_BUTTONS-1:0]         o_clicked,
    output logic [NUM_BUTTONS-1:0]         o_held,
    output logic                           o_scanned,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bchs_pkg::ADDR_BITS-1:0] paddr,
    input  logic [bchs_pkg::DATA_BITS-1:0] pwdata,
    output logic [bchs_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);

    logic [bchs_pkg::CFG_BITS-1:0] r_scan_interval;
    logic [bchs_pkg::CFG_BITS-1:0] r_hold_limit;

    logic                   r_in_valid;
    logic [NUM_BUTTONS-1:0] r_levels;
    logic [NUM_BUTTONS-1:0] r_reads;

    logic                   r_out_valid;
    logic [NUM_BUTTONS-1:0] r_clicked;
    logic [NUM_BUTTONS-1:0] r_held;
    logic                   r_scanned;

    logic [TIME_BITS-1:0]   r_tick;
    logic [TIME_BITS-1:0]   r_last_scan;
    logic [NUM_BUTTONS-1:0] r_was_pressed;
    logic [TIME_BITS-1:0]   r_press_time [NUM_BUTTONS];
    bchs_pkg::t_event       r_event      [NUM_BUTTONS];

    logic [TIME_BITS-1:0]   n_tick;
    logic                   n_scan;
    logic [NUM_BUTTONS-1:0] n_pressed;
    logic [TIME_BITS-1:0]   n_press_time [NUM_BUTTONS];
    bchs_pkg::t_event       n_event      [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] n_clicked;
    logic [NUM_BUTTONS-1:0] n_held;

    logic w_out_free;
    logic w_proc;
    logic w_load;
    logic w_cfg_wr;
    logic [TIME_BITS-1:0] w_hold;

    // pipeline control
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_proc     = r_in_valid && w_out_free;
    assign w_load     = i_valid && (!r_in_valid || w_out_free);
    assign o_stall    = r_in_valid && !w_out_free;

    assign o_valid   = r_out_valid;
    assign o_clicked = r_clicked;
    assign o_held    = r_held;
    assign o_scanned = r_scanned;

    // configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            bchs_pkg::REG_SCAN_INTERVAL: prdata = bchs_pkg::DATA_BITS'(r_scan_interval);
            bchs_pkg::REG_HOLD_LIMIT:    prdata = bchs_pkg::DATA_BITS'(r_hold_limit);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_interval <= bchs_pkg::SCAN_INTERVAL_RST;
            r_hold_limit    <= bchs_pkg::HOLD_LIMIT_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                bchs_pkg::REG_SCAN_INTERVAL: r_scan_interval <= pwdata[bchs_pkg::CFG_BITS-1:0];
                bchs_pkg::REG_HOLD_LIMIT:    r_hold_limit    <= pwdata[bchs_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // evaluation of one tick, all buttons in parallel
    assign w_hold = TIME_BITS'(r_hold_limit);

    always_comb begin
        logic [TIME_BITS-1:0] held_for;
        n_tick = r_tick + TIME_BITS'(1);
        n_scan = (n_tick - r_last_scan) >= TIME_BITS'(r_scan_interval);
        n_pressed = ~r_levels;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            held_for        = n_tick - r_press_time[i];
            n_press_time[i] = r_press_time[i];
            n_event[i]      = r_event[i];
            if (n_scan) begin
                if (!n_pressed[i] && r_was_pressed[i]) begin
                    n_event[i] = (held_for < w_hold) ? bchs_pkg::EV_CLICK : bchs_pkg::EV_IDLE;
                end
                if (n_pressed[i] && !r_was_pressed[i]) begin
                    n_press_time[i] = n_tick;
                end
                // a fresh press has zero duration and never counts as held
                if (n_pressed[i] && r_was_pressed[i] && (held_for > w_hold)) begin
                    n_event[i] = bchs_pkg::EV_HELD;
                end
            end
            n_clicked[i] = (n_event[i] == bchs_pkg::EV_CLICK);
            n_held[i]    = (n_event[i] == bchs_pkg::EV_HELD);
            // reading a pending click returns it to idle
            if (n_clicked[i] && r_reads[i]) begin
                n_event[i] = bchs_pkg::EV_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_tick        <= '0;
            r_last_scan   <= '0;
            r_was_pressed <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_press_time[i] <= '0;
                r_event[i]      <= bchs_pkg::EV_IDLE;
            end
        end else begin
            if (w_load) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_proc) begin
                r_tick <= n_tick;
                if (n_scan) begin
                    r_last_scan   <= n_tick;
                    r_was_pressed <= n_pressed;
                end
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    r_press_time[i] <= n_press_time[i];
                    r_event[i]      <= n_event[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_levels <= i_pin_levels;
            r_reads  <= i_read_clicks;
        end
        if (w_proc) begin
            r_clicked <= n_clicked;
            r_held    <= n_held;
            r_scanned <= n_scan;
        end
    end

    a_click_held_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_clicked & o_held) == '0))
        else $error("button reported as clicked and held at once");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |=> o_valid)
        else $error("evaluated tick produced no result");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |=> (r_tick == $past(r_tick) + TIME_BITS'(1)))
        else $error("tick counter did not advance on an evaluated tick");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free pipeline stage");

endmodule
